// ===== rtl/core/irb_pkg.sv =====
// shared types and constants for the rotated bilinear readout block
package irb_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_COS    = 2'd0;
  localparam logic [1:0] REG_SIN    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // input actions
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // fixed widths
  localparam int DIM_W  = 9;   // frame dimension in use
  localparam int TRIG_W = 10;  // signed q8 cosine and sine
  localparam int CRD_W  = 9;   // source row or column inside the frame
  localparam int WGT_W  = 4;   // blend weight
  localparam logic [WGT_W-1:0] WGT_MAX = 4'hF;

  // input item
  typedef struct packed {
    logic       action;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pixel_in;
  } irb_in_t;

  // result item
  typedef struct packed {
    logic [7:0] pixel_out;
    logic       inside_res;
  } irb_out_t;

  // source position and write fields handed to the frame store
  typedef struct packed {
    logic             is_req;
    logic             in_frame;
    logic [CRD_W-1:0] si;
    logic [CRD_W-1:0] sj;
    logic [WGT_W-1:0] wr;
    logic [WGT_W-1:0] wc;
    logic [7:0]       row;
    logic [7:0]       col;
    logic [7:0]       pixel;
  } irb_addr_t;

  // neighborhood handed to the blender
  typedef struct packed {
    logic             in_frame;
    logic [WGT_W-1:0] wr;
    logic [WGT_W-1:0] wc;
    logic [7:0]       p00;
    logic [7:0]       p01;
    logic [7:0]       p10;
    logic [7:0]       p11;
  } irb_nbr_t;

endpackage

// ===== rtl/core/irb_coord.sv =====
// coordinate stages: centering, rotation products, source position and weights
module irb_coord (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [irb_pkg::TRIG_W-1:0]   cos_q8,
  input  logic signed [irb_pkg::TRIG_W-1:0]   sin_q8,
  input  logic        [irb_pkg::DIM_W-1:0]    dim_w,
  input  logic        [irb_pkg::DIM_W-1:0]    dim_h,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  irb_pkg::irb_in_t                    src_data,
  output logic                                addr_valid,
  output irb_pkg::irb_addr_t                  addr,
  input  logic                                addr_take
);
  import irb_pkg::*;

  logic [7:0] half_w;
  logic [7:0] half_h;
  logic       en1, en2, en3;

  // stage 1 registers
  logic               v1, act1, ok1;
  logic signed [9:0]  it1, jt1;
  logic [7:0]         row1, col1, pix1;
  // stage 2 registers
  logic               v2, act2, ok2;
  logic signed [19:0] pic, pjs, pis, pjc;
  logic [7:0]         row2, col2, pix2;

  logic signed [9:0]  it_c, jt_c;
  logic               ok_c;
  logic signed [20:0] ir, jr;
  logic signed [13:0] si_c, sj_c;
  logic               in_c;

  assign half_w = dim_w[DIM_W-1:1];
  assign half_h = dim_h[DIM_W-1:1];

  // stage moves when empty or when its successor moves
  assign en3       = !addr_valid || addr_take;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign src_stall = !en1;

  // centering and last row or column check
  assign it_c = $signed({2'b0, src_data.row}) - $signed({2'b0, half_h});
  assign jt_c = $signed({2'b0, src_data.col}) - $signed({2'b0, half_w});
  assign ok_c = ({1'b0, src_data.row} < dim_h - 9'd1) && ({1'b0, src_data.col} < dim_w - 9'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      act1 <= src_data.action;
      ok1  <= ok_c;
      it1  <= it_c;
      jt1  <= jt_c;
      row1 <= src_data.row;
      col1 <= src_data.col;
      pix1 <= src_data.pixel_in;
    end
  end

  // rotation products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      act2 <= act1;
      ok2  <= ok1;
      pic  <= it1 * cos_q8;
      pjs  <= jt1 * sin_q8;
      pis  <= it1 * sin_q8;
      pjc  <= jt1 * cos_q8;
      row2 <= row1;
      col2 <= col1;
      pix2 <= pix1;
    end
  end

  // rotated position, floor by 256 and interior check
  assign ir   = pic - pjs;
  assign jr   = pis + pjc;
  assign si_c = 14'(ir >>> 8) + $signed({6'b0, half_h}) - 14'sd1;
  assign sj_c = 14'(jr >>> 8) + $signed({6'b0, half_w}) - 14'sd1;
  assign in_c = (si_c > 14'sd0) && (si_c < $signed({5'b0, dim_h}) - 14'sd1) &&
                (sj_c > 14'sd0) && (sj_c < $signed({5'b0, dim_w}) - 14'sd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else if (en3) begin
      addr_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      addr.is_req   <= (act2 == ACT_REQUEST);
      addr.in_frame <= ok2 && in_c;
      addr.si       <= si_c[CRD_W-1:0];
      addr.sj       <= sj_c[CRD_W-1:0];
      addr.wr       <= ir[7:4];
      addr.wc       <= jr[7:4];
      addr.row      <= row2;
      addr.col      <= col2;
      addr.pixel    <= pix2;
    end
  end

endmodule

// ===== rtl/core/irb_frame.sv =====
// frame store in four banks by row and column parity, one 2x2 read per cycle while the blender takes
module irb_frame #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               addr_valid,
  input  irb_pkg::irb_addr_t addr,
  output logic               addr_take,
  output logic               nbr_valid,
  output irb_pkg::irb_nbr_t  nbr,
  input  logic               nbr_take
);
  import irb_pkg::*;

  localparam int RB    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 2;
  localparam int CB    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int RH    = RB - 1;
  localparam int CH    = CB - 1;
  localparam int DEPTH = 1 << (RH + CH);

  logic              en4;
  logic              wr_ok;
  logic [CRD_W:0]    si_p1, sj_p1;
  logic [RH-1:0]     rd_row [2];
  logic [CH-1:0]     rd_col [2];
  logic [RH-1:0]     wr_row;
  logic [CH-1:0]     wr_col;
  logic [7:0]        q [2][2];
  logic              in_frame4, si0, sj0;
  logic [WGT_W-1:0]  wr4, wc4;

  assign en4       = !nbr_valid || nbr_take;
  assign addr_take = en4;

  // bank row and column indexes for the even and odd parity banks
  assign si_p1     = {1'b0, addr.si} + 10'd1;
  assign sj_p1     = {1'b0, addr.sj} + 10'd1;
  assign rd_row[0] = RH'(si_p1 >> 1);
  assign rd_row[1] = RH'(addr.si >> 1);
  assign rd_col[0] = CH'(sj_p1 >> 1);
  assign rd_col[1] = CH'(addr.sj >> 1);

  // write location and range check
  assign wr_row = RH'(addr.row >> 1);
  assign wr_col = CH'(addr.col >> 1);
  assign wr_ok  = addr_valid && !addr.is_req &&
                  (32'(addr.row) < MAX_HEIGHT) && (32'(addr.col) < MAX_WIDTH);

  // banks
  for (genvar gr = 0; gr < 2; gr++) begin : g_row
    for (genvar gc = 0; gc < 2; gc++) begin : g_col
      logic [7:0] mem [DEPTH];

      always_ff @(posedge clk) begin
        if (en4 && wr_ok && (addr.row[0] == gr[0]) && (addr.col[0] == gc[0])) begin
          mem[{wr_row, wr_col}] <= addr.pixel;
        end
      end

      always_ff @(posedge clk) begin
        if (en4) begin
          q[gr][gc] <= mem[{rd_row[gr], rd_col[gc]}];
        end
      end
    end
  end

  // side data that travels with the read
  always_ff @(posedge clk) begin
    if (rst) begin
      nbr_valid <= 1'b0;
    end else if (en4) begin
      nbr_valid <= addr_valid && addr.is_req;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      in_frame4 <= addr.in_frame;
      wr4       <= addr.wr;
      wc4       <= addr.wc;
      si0       <= addr.si[0];
      sj0       <= addr.sj[0];
    end
  end

  // put the bank outputs back in neighborhood order
  assign nbr.in_frame = in_frame4;
  assign nbr.wr       = wr4;
  assign nbr.wc       = wc4;
  assign nbr.p00      = q[si0][sj0];
  assign nbr.p01      = q[si0][!sj0];
  assign nbr.p10      = q[!si0][sj0];
  assign nbr.p11      = q[!si0][!sj0];

endmodule

// ===== rtl/core/irb_blend.sv =====
// blend stages: row blends, column blend and result register
module irb_blend (
  input  logic              clk,
  input  logic              rst,
  input  logic              nbr_valid,
  input  irb_pkg::irb_nbr_t nbr,
  output logic              nbr_take,
  output logic              dst_valid,
  input  logic              dst_stall,
  output irb_pkg::irb_out_t dst_data
);
  import irb_pkg::*;

  logic             en5, en6;
  logic             v5, in_frame5;
  logic [11:0]      v0, v1;
  logic [WGT_W-1:0] wc5;
  logic [WGT_W-1:0] nwr, nwc;
  logic [15:0]      sum;

  assign en6      = !dst_valid || !dst_stall;
  assign en5      = !v5 || en6;
  assign nbr_take = en5;

  assign nwr = WGT_MAX - nbr.wr;
  assign nwc = WGT_MAX - wc5;

  // blend along rows
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= nbr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      v0        <= 12'(nwr) * 12'(nbr.p00) + 12'(nbr.wr) * 12'(nbr.p10);
      v1        <= 12'(nwr) * 12'(nbr.p01) + 12'(nbr.wr) * 12'(nbr.p11);
      wc5       <= nbr.wc;
      in_frame5 <= nbr.in_frame;
    end
  end

  // blend along columns
  assign sum = 16'(nwc) * 16'(v0) + 16'(wc5) * 16'(v1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (en6) begin
      dst_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      dst_data.pixel_out  <= in_frame5 ? sum[15:8] : 8'd0;
      dst_data.inside_res <= in_frame5;
    end
  end

endmodule

// ===== rtl/core/image_rotate_bilinear.sv =====
// top level of the rotated bilinear readout block
//
//  channel  direction  handshake              payload
//  src      in         src_valid / src_stall  irb_in_t: action, row, col, pixel_in
//  dst      out        dst_valid / dst_stall  irb_out_t: pixel_out, inside_res
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle while dst is not stalled
// the four parity banks of the frame store give the 2x2 neighborhood in one read
// reset clears valid bits and loads register defaults; the store is not cleared
// each stage loads when empty or when the next stage moves, so bubbles collapse
// src_stall rises only when every stage is full and dst is stalled
module image_rotate_bilinear #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  irb_pkg::irb_in_t  src_data,
  output logic              dst_valid,
  input  logic              dst_stall,
  output irb_pkg::irb_out_t dst_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_data
);
  import irb_pkg::*;

  logic signed [TRIG_W-1:0] cos_q8, sin_q8;
  logic [DIM_W-1:0]         image_width, image_height;
  logic [DIM_W-1:0]         dim_w, dim_h;
  logic                     addr_valid, addr_take;
  irb_addr_t                addr;
  logic                     nbr_valid, nbr_take;
  irb_nbr_t                 nbr;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_q8       <= 10'sd256;
      sin_q8       <= 10'sd0;
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COS:    cos_q8       <= $signed(cfg_data);
        REG_SIN:    sin_q8       <= $signed(cfg_data);
        REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate dimensions into the store
  always_comb begin
    if (image_width < 9'd2) begin
      dim_w = 9'd2;
    end else if (32'(image_width) > MAX_WIDTH) begin
      dim_w = DIM_W'(MAX_WIDTH);
    end else begin
      dim_w = image_width;
    end
    if (image_height < 9'd2) begin
      dim_h = 9'd2;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      dim_h = DIM_W'(MAX_HEIGHT);
    end else begin
      dim_h = image_height;
    end
  end

  irb_coord u_coord (
    .clk        (clk),
    .rst        (rst),
    .cos_q8     (cos_q8),
    .sin_q8     (sin_q8),
    .dim_w      (dim_w),
    .dim_h      (dim_h),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_data   (src_data),
    .addr_valid (addr_valid),
    .addr       (addr),
    .addr_take  (addr_take)
  );

  irb_frame #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .addr_valid (addr_valid),
    .addr       (addr),
    .addr_take  (addr_take),
    .nbr_valid  (nbr_valid),
    .nbr        (nbr),
    .nbr_take   (nbr_take)
  );

  irb_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .nbr_valid (nbr_valid),
    .nbr       (nbr),
    .nbr_take  (nbr_take),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule

// ===== rtl/core/irb_check.sv =====
// port checker for the rotated bilinear readout block and its bind
module irb_check (
  input logic              clk,
  input logic              rst,
  input logic              src_stall,
  input logic              dst_valid,
  input logic              dst_stall,
  input irb_pkg::irb_out_t dst_data
);

  // input backs up only when the result side is stalled
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (dst_valid && dst_stall))
    else $error("src stalled while dst free");

  // an outside result carries a zero pixel
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && !dst_data.inside_res) |-> (dst_data.pixel_out == 8'd0))
    else $error("outside result with nonzero pixel");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_stall) |=> (dst_valid && $stable(dst_data)))
    else $error("stalled result changed");

endmodule

bind image_rotate_bilinear irb_check u_irb_check (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_data  (dst_data)
);
